@@ rtl/core/hds_pkg.sv @@
// ----------------------------------------------------------------------------
// hds_pkg: shared types and constants for the heat diffusion stencil sweep
// Field widths, grid limits, register map and reset values.
// ----------------------------------------------------------------------------
package hds_pkg;

	localparam int TEMP_BITS = 25;                  // unsigned Q9.16
	localparam int GRID_MAX  = 1024;                // deepest line store
	localparam int POS_W     = $clog2(GRID_MAX);    // row / column index
	localparam int SIZE_W    = 11;                  // grid_size register
	localparam int GRID_MIN  = 2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int GRID_RESET = 100;
	localparam int SRC_RESET  = 25;

	typedef logic [TEMP_BITS-1:0] temp_t;
	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [SIZE_W-1:0]    gsize_t;

	// register index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_GRID_SIZE  = 2'd0,
		REG_SOURCE_ROW = 2'd1,
		REG_SOURCE_COL = 2'd2
	} reg_idx_t;

endpackage

@@ rtl/core/hds_temp_if.sv @@
// ----------------------------------------------------------------------------
// hds_temp_if: input channel of the stencil sweep
// One word carries one cell temperature, raster order.
// ----------------------------------------------------------------------------
interface hds_temp_if;
	import hds_pkg::*;

	logic  valid;
	logic  ready;
	temp_t temperature;

	modport source (output valid, output temperature, input ready);
	modport sink   (input valid, input temperature, output ready);

endinterface

@@ rtl/core/hds_result_if.sv @@
// ----------------------------------------------------------------------------
// hds_result_if: result channel of the stencil sweep
// One word carries one updated cell with its position and markers.
// ----------------------------------------------------------------------------
interface hds_result_if;
	import hds_pkg::*;

	logic  valid;
	logic  ready;
	temp_t new_temperature;
	pos_t  out_row;
	pos_t  out_col;
	logic  run_last;
	logic  sweep_done;

	modport source (
		output valid, output new_temperature, output out_row, output out_col,
		output run_last, output sweep_done, input ready
	);
	modport sink (
		input valid, input new_temperature, input out_row, input out_col,
		input run_last, input sweep_done, output ready
	);

endinterface

@@ rtl/core/heat_diffusion_stencil_sweep.sv @@
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_sweep: one Jacobi 5-point sweep over a square grid
// Streams cells in raster order, emits updated cells one row behind.
// ----------------------------------------------------------------------------
// The block takes one cell word per cycle on samples while samples.ready is
// high and returns updated cells on results, one row behind the input: the
// word for cell (r, c) releases the update of cell (r-1, c). On the last
// grid row each input past column 0 also releases the update of its left
// neighbour, and the last cell releases itself, so last-row words past
// column 0 release two results (three for the final cell), sent at most one
// per cycle. Stage 1 holds the word, the output register its result. The two
// previous grid rows live in two line memories (middle: row r-1, upper: row
// r-2) with synchronous reads; the middle memory is read at c and c+1 and
// written with the new cell at the same edge, the upper memory takes the old
// middle value of the previous column on the next accepted word. Line
// memories are not cleared after reset; values from unwritten entries never
// reach a result in a normal sweep. Configuration goes through the APB port
// (grid_size at 0x0, source_row at 0x4, source_col at 0x8); the user must
// write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_sweep (
	input  logic                         clk,
	input  logic                         arst_n,
	hds_temp_if.sink                     samples,
	hds_result_if.source                 results,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hds_pkg::PADDR_W-1:0]  paddr,
	input  logic [hds_pkg::PDATA_W-1:0]  pwdata,
	output logic [hds_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import hds_pkg::*;

	// which of the up to three results of the held word is being emitted
	typedef enum logic [1:0] {
		SEL_ABOVE = 2'd0,   // (r-1, c)
		SEL_LEFT  = 2'd1,   // (r, c-1), last row only
		SEL_LAST  = 2'd2    // (r, c), final cell
	} sel_t;

	function automatic gsize_t clamp_size(input gsize_t v);
		gsize_t res;
		res = v;
		if (v < gsize_t'(GRID_MIN)) res = gsize_t'(GRID_MIN);
		if (v > gsize_t'(GRID_MAX)) res = gsize_t'(GRID_MAX);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	gsize_t   grid_size_q;
	gsize_t   n_q;            // clamped grid size
	pos_t     source_row_q;
	pos_t     source_col_q;
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q  <= gsize_t'(GRID_RESET);
			n_q          <= clamp_size(gsize_t'(GRID_RESET));
			source_row_q <= pos_t'(SRC_RESET);
			source_col_q <= pos_t'(SRC_RESET);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_GRID_SIZE: begin
					grid_size_q <= pwdata[SIZE_W-1:0];
					n_q         <= clamp_size(pwdata[SIZE_W-1:0]);
				end
				REG_SOURCE_ROW: source_row_q <= pwdata[POS_W-1:0];
				REG_SOURCE_COL: source_col_q <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_GRID_SIZE:  prdata[SIZE_W-1:0] = grid_size_q;
			REG_SOURCE_ROW: prdata[POS_W-1:0]  = source_row_q;
			REG_SOURCE_COL: prdata[POS_W-1:0]  = source_col_q;
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// input position and per-word result mask
	// ------------------------------------------------------------------
	pos_t       row_q, col_q;
	pos_t       n_last;
	logic       pos_wrap;
	pos_t       r_a, c_a;
	logic       row_end_a, col_end_a;
	logic [2:0] mask_a;
	logic       accept;

	assign n_last = pos_t'(n_q - gsize_t'(1));

	// a shrunk grid restarts the scan at the origin
	assign pos_wrap  = (gsize_t'(row_q) >= n_q) || (gsize_t'(col_q) >= n_q);
	assign r_a       = pos_wrap ? '0 : row_q;
	assign c_a       = pos_wrap ? '0 : col_q;
	assign row_end_a = (r_a == n_last);
	assign col_end_a = (c_a == n_last);
	assign mask_a    = {row_end_a && col_end_a, row_end_a && (c_a != '0), r_a != '0};
	assign accept    = samples.valid && samples.ready;

	// ------------------------------------------------------------------
	// stage 1: word held with its line-memory reads
	// ------------------------------------------------------------------
	temp_t      middle_mem [GRID_MAX];
	temp_t      upper_mem  [GRID_MAX];
	temp_t      mid0_s1, mid1_s1, up_s1, x_s1;
	pos_t       row_s1, col_s1;
	logic [2:0] pend_s1;        // results still to emit
	logic       upd_pend_q;     // upper line write owed by the held word
	temp_t      lh_q;           // row r-1 at column c-1
	temp_t      xp1_q, xp2_q;   // row r at columns c-1, c-2

	always_ff @(posedge clk) begin
		if (accept) begin
			mid0_s1          <= middle_mem[c_a];
			mid1_s1          <= middle_mem[c_a + pos_t'(1)];
			up_s1            <= upper_mem[c_a];
			middle_mem[c_a]  <= samples.temperature;
			// previous column never equals c_a, so no read/write overlap
			if (upd_pend_q) upper_mem[col_s1] <= mid0_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= samples.temperature;
			row_s1 <= r_a;
			col_s1 <= c_a;
			lh_q   <= mid0_s1;
			xp1_q  <= x_s1;
			xp2_q  <= xp1_q;
		end
	end

	// ------------------------------------------------------------------
	// result select and stencil
	// ------------------------------------------------------------------
	sel_t                 sel;
	logic [2:0]           sel_bit, rest;
	temp_t                ctr, op_l, op_r, op_u, op_d, res;
	pos_t                 rr, cc;
	logic [TEMP_BITS+1:0] sum;
	logic                 c_nz, c_ge2, c_end, r_ge2;

	assign c_nz  = (col_s1 != '0);
	assign c_ge2 = (col_s1 >= pos_t'(2));
	assign c_end = (col_s1 == n_last);
	assign r_ge2 = (row_s1 >= pos_t'(2));

	always_comb begin
		if (pend_s1[0]) begin
			sel     = SEL_ABOVE;
			sel_bit = 3'b001;
		end else if (pend_s1[1]) begin
			sel     = SEL_LEFT;
			sel_bit = 3'b010;
		end else begin
			sel     = SEL_LAST;
			sel_bit = 3'b100;
		end
	end

	assign rest = pend_s1 & ~sel_bit;

	// out-of-grid neighbours fall back to the center cell
	always_comb begin
		case (sel)
			SEL_ABOVE: begin
				ctr  = mid0_s1;
				op_l = c_nz ? lh_q : mid0_s1;
				op_r = c_end ? mid0_s1 : mid1_s1;
				op_u = r_ge2 ? up_s1 : mid0_s1;
				op_d = x_s1;
				rr   = row_s1 - pos_t'(1);
				cc   = col_s1;
			end
			SEL_LEFT: begin
				ctr  = xp1_q;
				op_l = c_ge2 ? xp2_q : xp1_q;
				op_r = x_s1;
				op_u = lh_q;
				op_d = xp1_q;
				rr   = row_s1;
				cc   = col_s1 - pos_t'(1);
			end
			default: begin
				ctr  = x_s1;
				op_l = xp1_q;
				op_r = x_s1;
				op_u = mid0_s1;
				op_d = x_s1;
				rr   = row_s1;
				cc   = col_s1;
			end
		endcase
	end

	assign sum = {2'b00, op_l} + {2'b00, op_r} + {2'b00, op_u} + {2'b00, op_d};
	assign res = ((rr == source_row_q) && (cc == source_col_q)) ? ctr
	             : sum[TEMP_BITS+1:2];

	// ------------------------------------------------------------------
	// handshake and output register
	// ------------------------------------------------------------------
	logic  out_valid_q;
	logic  out_free, s1_busy, emit;
	temp_t new_temperature_q;
	pos_t  out_row_q, out_col_q;
	logic  run_last_q, sweep_done_q;

	assign s1_busy       = (pend_s1 != '0);
	assign out_free      = !out_valid_q || results.ready;
	assign emit          = s1_busy && out_free;
	assign samples.ready = !s1_busy || (emit && (rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			pend_s1     <= '0;
			upd_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pend_s1    <= mask_a;
				upd_pend_q <= 1'b1;
				if (col_end_a) begin
					col_q <= '0;
					row_q <= row_end_a ? '0 : r_a + pos_t'(1);
				end else begin
					col_q <= c_a + pos_t'(1);
					row_q <= r_a;
				end
			end else if (emit) begin
				pend_s1 <= rest;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			new_temperature_q <= res;
			out_row_q         <= rr;
			out_col_q         <= cc;
			run_last_q        <= (rest == '0);
			sweep_done_q      <= (sel == SEL_LAST);
		end
	end

	assign results.valid           = out_valid_q;
	assign results.new_temperature = new_temperature_q;
	assign results.out_row         = out_row_q;
	assign results.out_col         = out_col_q;
	assign results.run_last        = run_last_q;
	assign results.sweep_done      = sweep_done_q;

endmodule
